[rtl/adz_pkg.sv]
// Shared constants, types and register codes of the axis dead zone scaler.
package adz_pkg;

  localparam int ADC_BITS_DEF = 12;
  localparam int AXIS_BITS    = 16;
  localparam int DZ_BITS      = 15;
  localparam int AXIS_FULL    = 32767;

  typedef enum logic [1:0] {
    REG_ADC_LOW   = 2'd0,
    REG_ADC_HIGH  = 2'd1,
    REG_DZ_WIDTH  = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MAP_DIV    = 2'd0,
    MAP_SAT_LO = 2'd1,
    MAP_SAT_HI = 2'd2
  } map_mode_t;

  typedef struct packed {
    logic      fault;
    map_mode_t mode;
  } map_side_t;

  typedef struct packed {
    logic fault;
    logic zero;
    logic neg;
  } dz_side_t;

  localparam int SIDE_BITS = $bits(map_side_t);

endpackage

[rtl/axis_dead_zone_scaler.sv]
// Top level: calibrated ADC span to signed axis with dead zone rescaling.
// An item passes stages S and P, the map divider, stages A, B and C, the dead
// zone divider and the output stage. Throughput: one item per cycle; busy stays low.
// Dividers of 16 and 15 stages (one quotient bit per stage); six map and output stages.
// The receiver cannot stall; each result shows on out_valid for exactly one cycle.
// Reset clears all pipeline valid bits; adc_low = 0, adc_high = all ones, dz width = 0.
module axis_dead_zone_scaler import adz_pkg::*; #(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [ADC_BITS-1:0]        in_adc_sample,
  output logic                       out_valid,
  output logic signed [AXIS_BITS-1:0] out_axis_value,
  output logic                       out_config_fault,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [((ADC_BITS > DZ_BITS) ? ADC_BITS : DZ_BITS)-1:0] cfg_wdata
);

  localparam int N       = ADC_BITS;
  localparam int Q1      = AXIS_BITS;
  localparam int Q2      = DZ_BITS;
  localparam int LATENCY = 6 + Q1 + Q2;
  localparam logic [Q1-1:0] FULL_Q1 = Q1'(AXIS_FULL);
  localparam logic [DZ_BITS-1:0] FULL_DZ = DZ_BITS'(AXIS_FULL);

  // configuration registers
  logic [N-1:0]       adc_low_r, adc_low_nxt;
  logic [N-1:0]       adc_high_r, adc_high_nxt;
  logic [DZ_BITS-1:0] dz_r, dz_nxt;

  always_comb begin
    adc_low_nxt  = adc_low_r;
    adc_high_nxt = adc_high_r;
    dz_nxt       = dz_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ADC_LOW:   adc_low_nxt  = cfg_wdata[N-1:0];
        REG_ADC_HIGH:  adc_high_nxt = cfg_wdata[N-1:0];
        REG_DZ_WIDTH:  dz_nxt       = cfg_wdata[DZ_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adc_low_r  <= '0;
      adc_high_r <= '1;
      dz_r       <= '0;
    end else begin
      adc_low_r  <= adc_low_nxt;
      adc_high_r <= adc_high_nxt;
      dz_r       <= dz_nxt;
    end
  end

  assign busy = 1'b0;

  // stage S: input register
  logic         s_vld_r;
  logic [N-1:0] s_smp_r;

  // stage P: span map and first dividend
  logic          p_vld_r;
  logic [N+Q1-1:0] p_num_r, p_num_nxt;
  logic [N-1:0]  p_den_r, p_den_nxt;
  map_side_t     p_side_r, p_side_nxt;

  always_comb begin
    logic [N-1:0] span;
    logic [N-1:0] dif;
    span = adc_high_r - adc_low_r;
    dif  = s_smp_r - adc_low_r;
    p_side_nxt.fault = (adc_high_r <= adc_low_r);
    if (s_smp_r <= adc_low_r) begin
      p_side_nxt.mode = MAP_SAT_LO;
    end else if (dif >= span) begin
      p_side_nxt.mode = MAP_SAT_HI;
    end else begin
      p_side_nxt.mode = MAP_DIV;
    end
    // dif * 65534 = dif * 2^16 - dif * 2
    if (!p_side_nxt.fault && (p_side_nxt.mode == MAP_DIV)) begin
      p_num_nxt = {dif, {Q1{1'b0}}} - {{(Q1-1){1'b0}}, dif, 1'b0};
      p_den_nxt = span;
    end else begin
      p_num_nxt = '0;
      p_den_nxt = N'(1);
    end
  end

  logic          d1_vld;
  logic [Q1-1:0] d1_quot;
  logic [$bits(map_side_t)-1:0] d1_side_bits;
  map_side_t     d1_side;

  adz_pipe_div #(.DW(N), .QB(Q1), .SW($bits(map_side_t))) u_div_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (p_vld_r),
    .in_num    (p_num_r),
    .in_den    (p_den_r),
    .in_side   (p_side_r),
    .out_valid (d1_vld),
    .out_quot  (d1_quot),
    .out_side  (d1_side_bits)
  );

  assign d1_side = map_side_t'(d1_side_bits);

  // stage A: magnitude and sign of the mapped value
  logic               a_vld_r;
  logic [DZ_BITS-1:0] a_abs_r, a_abs_nxt;
  logic               a_neg_r, a_neg_nxt;
  logic               a_fault_r;

  always_comb begin
    case (d1_side.mode)
      MAP_SAT_HI: begin
        a_abs_nxt = FULL_DZ;
        a_neg_nxt = 1'b0;
      end
      MAP_SAT_LO: begin
        a_abs_nxt = FULL_DZ;
        a_neg_nxt = 1'b1;
      end
      default: begin
        if (d1_quot >= FULL_Q1) begin
          a_abs_nxt = DZ_BITS'(d1_quot - FULL_Q1);
          a_neg_nxt = 1'b0;
        end else begin
          a_abs_nxt = DZ_BITS'(FULL_Q1 - d1_quot);
          a_neg_nxt = 1'b1;
        end
      end
    endcase
  end

  // stage B: dead zone test and remaining span
  logic               b_vld_r;
  logic [DZ_BITS-1:0] b_mag_r, b_den_r;
  logic               b_zero_r, b_neg_r, b_fault_r;

  // stage C: second dividend
  logic               c_vld_r;
  logic [2*Q2-1:0]    c_num_r, c_num_nxt;
  logic [Q2-1:0]      c_den_r, c_den_nxt;
  dz_side_t           c_side_r, c_side_nxt;

  always_comb begin
    c_side_nxt.fault = b_fault_r;
    c_side_nxt.zero  = b_zero_r;
    c_side_nxt.neg   = b_neg_r;
    // mag * 32767 = mag * 2^15 - mag
    if (b_zero_r || b_fault_r) begin
      c_num_nxt = '0;
      c_den_nxt = Q2'(1);
    end else begin
      c_num_nxt = {b_mag_r, {Q2{1'b0}}} - {{Q2{1'b0}}, b_mag_r};
      c_den_nxt = b_den_r;
    end
  end

  logic          d2_vld;
  logic [Q2-1:0] d2_quot;
  logic [$bits(dz_side_t)-1:0] d2_side_bits;
  dz_side_t      d2_side;

  adz_pipe_div #(.DW(Q2), .QB(Q2), .SW($bits(dz_side_t))) u_div_dz (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (c_vld_r),
    .in_num    (c_num_r),
    .in_den    (c_den_r),
    .in_side   (c_side_r),
    .out_valid (d2_vld),
    .out_quot  (d2_quot),
    .out_side  (d2_side_bits)
  );

  assign d2_side = dz_side_t'(d2_side_bits);

  // output stage
  logic                 out_vld_r;
  logic [AXIS_BITS-1:0] out_axis_r, out_axis_nxt;
  logic                 out_fault_r;

  always_comb begin
    logic [AXIS_BITS-1:0] mag;
    mag = {1'b0, d2_quot};
    if (d2_side.fault || d2_side.zero) begin
      out_axis_nxt = '0;
    end else if (d2_side.neg) begin
      out_axis_nxt = -mag;
    end else begin
      out_axis_nxt = mag;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r   <= 1'b0;
      p_vld_r   <= 1'b0;
      a_vld_r   <= 1'b0;
      b_vld_r   <= 1'b0;
      c_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s_vld_r   <= start && !busy;
      p_vld_r   <= s_vld_r;
      a_vld_r   <= d1_vld;
      b_vld_r   <= a_vld_r;
      c_vld_r   <= b_vld_r;
      out_vld_r <= d2_vld;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    s_smp_r     <= in_adc_sample;
    p_num_r     <= p_num_nxt;
    p_den_r     <= p_den_nxt;
    p_side_r    <= p_side_nxt;
    a_abs_r     <= a_abs_nxt;
    a_neg_r     <= a_neg_nxt;
    a_fault_r   <= d1_side.fault;
    b_zero_r    <= (a_abs_r <= dz_r);
    b_mag_r     <= a_abs_r - dz_r;
    b_den_r     <= FULL_DZ - dz_r;
    b_neg_r     <= a_neg_r;
    b_fault_r   <= a_fault_r;
    c_num_r     <= c_num_nxt;
    c_den_r     <= c_den_nxt;
    c_side_r    <= c_side_nxt;
    out_axis_r  <= out_axis_nxt;
    out_fault_r <= d2_side.fault;
  end

  assign out_valid        = out_vld_r;
  assign out_axis_value   = out_axis_r;
  assign out_config_fault = out_fault_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> $past(start, LATENCY))
    else $error("result without an accepted item");

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_fault_r) |-> (out_axis_r == '0))
    else $error("faulted item with nonzero axis value");

  a_no_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_axis_r != {1'b1, {(AXIS_BITS-1){1'b0}}}))
    else $error("axis value outside symmetric range");

  a_dz_span: assert property (@(posedge clk) disable iff (!rst_n)
    (b_vld_r && !b_zero_r) |-> (b_mag_r <= b_den_r))
    else $error("dead zone remainder exceeds rescale span");

endmodule

[rtl/adz_pipe_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with a sideband.
module adz_pipe_div import adz_pkg::*; #(
  parameter int DW = ADC_BITS_DEF,
  parameter int QB = AXIS_BITS,
  parameter int SW = SIDE_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [DW+QB-1:0] in_num,
  input  logic [DW-1:0]    in_den,
  input  logic [SW-1:0]    in_side,
  output logic             out_valid,
  output logic [QB-1:0]    out_quot,
  output logic [SW-1:0]    out_side
);

  localparam int NW = DW + QB;

  logic [QB-1:0] vld_r;
  logic [NW-1:0] w_r   [QB];
  logic [NW-1:0] w_nxt [QB];
  logic [NW-1:0] src_w [QB];
  logic [DW-1:0] d_r   [QB];
  logic [DW-1:0] src_d [QB];
  logic [SW-1:0] s_r   [QB];
  logic [SW-1:0] src_s [QB];

  // Stage k takes the word left by stage k-1; stage 0 takes the input item.
  always_comb begin
    src_w[0] = in_num;
    src_d[0] = in_den;
    src_s[0] = in_side;
    for (int k = 1; k < QB; k++) begin
      src_w[k] = w_r[k-1];
      src_d[k] = d_r[k-1];
      src_s[k] = s_r[k-1];
    end
  end

  // Upper DW bits hold the partial remainder, lower QB bits shift out
  // dividend bits and shift in quotient bits.
  always_comb begin : div_step
    logic [DW:0] trial;
    logic [DW:0] diff;
    for (int k = 0; k < QB; k++) begin
      trial = src_w[k][NW-1:QB-1];
      diff  = trial - {1'b0, src_d[k]};
      if (trial >= {1'b0, src_d[k]}) begin
        w_nxt[k] = {diff[DW-1:0], src_w[k][QB-2:0], 1'b1};
      end else begin
        w_nxt[k] = {trial[DW-1:0], src_w[k][QB-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[QB-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QB; k++) begin
      w_r[k] <= w_nxt[k];
      d_r[k] <= src_d[k];
      s_r[k] <= src_s[k];
    end
  end

  assign out_valid = vld_r[QB-1];
  assign out_quot  = w_r[QB-1][QB-1:0];
  assign out_side  = s_r[QB-1];

  a_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid |-> (in_num[NW-1:QB] < in_den))
    else $error("divider item enters with quotient overflow");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_valid, QB))
    else $error("divider result without matching item");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (w_r[QB-1][NW-1:QB] < d_r[QB-1]))
    else $error("divider remainder not below divisor");

endmodule
